[design/rbsi_pkg.sv]
`timescale 1ns / 1ps
package rbsi_pkg;
   localparam int COORD_W   = 32;
   localparam int AXES      = 3;
   localparam int LANES     = 6;
   localparam int PT_W      = 33;
   localparam int NUM_W     = 35;
   localparam int MAG_W     = 33;
   localparam int FRAC_W    = 16;
   localparam int DIV_STEPS = MAG_W + FRAC_W;
   localparam int T_W       = 52;
   localparam int DIST_W    = 31;
   localparam int IN_W      = 12 * COORD_W;
   localparam int OUT_W     = 32;

   localparam logic signed [T_W-1:0] T_POS_INF = 52'sh4_0000_0000_0000;
   localparam logic signed [T_W-1:0] T_NEG_INF = 52'shC_0000_0000_0000;
   localparam logic signed [T_W-1:0] DIST_MAX  = 52'sh0_0000_7FFF_FFFF;

   typedef struct packed {
      logic [COORD_W-1:0]   dd;
      logic [DIV_STEPS-1:0] sh;
      logic [COORD_W-1:0]   rem;
      logic                 neg;
   } div_lane_type;

   typedef struct packed {
      logic            miss;
      logic [AXES-1:0] unb;
   } side_type;
endpackage

[design/ray_box_slab_intersect.sv]
`timescale 1ns / 1ps
// Ray against axis-aligned box, slab test, fully pipelined.
// req channel: one beat per test; tdata holds origin x/y/z, direction x/y/z,
// box center x/y/z, box half extent x/y/z, 32-bit signed Q16.16 each,
// origin x in the lowest bits.
// rsp channel: one beat per test; tdata bit 0 = hit, bits 31:1 = distance
// (Q16.16, saturated at 0x7FFFFFFF, zero on a miss).
// The pipe has three setup stages, 49 restoring-divider stages (one quotient
// bit per stage, six lanes in parallel), then sign fix, per-axis sort, two
// min/max stages and the output register. Throughput is one test per cycle
// while the rsp side is not stalled.
// Each stage holds a valid bit and advances when the stage after it is
// empty or advancing, so a stalled rsp side fills bubbles first and then
// backs up to req_tready; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; the pipe comes up empty.
module ray_box_slab_intersect (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // origin x,y,z; dir x,y,z; center x,y,z; half x,y,z
   input  logic [rbsi_pkg::IN_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit, distance[30:0]
   output logic [rbsi_pkg::OUT_W-1:0] rsp_tdata
);
   import rbsi_pkg::*;

   localparam int DIV0 = 2;
   localparam int FIX  = DIV0 + DIV_STEPS + 1;
   localparam int AXS  = FIX + 1;
   localparam int CMB1 = AXS + 1;
   localparam int CMB2 = CMB1 + 1;
   localparam int OUTS = CMB2 + 1;
   localparam int NST  = OUTS + 1;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] rdy;

   always_comb begin
      rdy[NST-1] = !v_ff[NST-1] || rsp_tready;
      for (int i = NST - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign req_tready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NST; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // stage 0: corners
   logic signed [COORD_W-1:0] o0_ff [AXES];
   logic signed [COORD_W-1:0] d0_ff [AXES];
   logic signed [PT_W-1:0]    p1_ff [AXES];
   logic signed [PT_W-1:0]    p2_ff [AXES];

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int a = 0; a < AXES; a++) begin
            logic signed [PT_W-1:0] c;
            logic signed [PT_W-1:0] h;
            c = PT_W'(signed'(req_tdata[(6+a)*COORD_W +: COORD_W]));
            h = PT_W'(signed'(req_tdata[(9+a)*COORD_W +: COORD_W]));
            o0_ff[a] <= req_tdata[a*COORD_W +: COORD_W];
            d0_ff[a] <= req_tdata[(3+a)*COORD_W +: COORD_W];
            p1_ff[a] <= c + h;
            p2_ff[a] <= c - h;
         end
      end
   end

   // stage 1: numerators
   logic signed [COORD_W-1:0] d1_ff   [AXES];
   logic signed [NUM_W-1:0]   nlo_ff  [AXES];
   logic signed [NUM_W-1:0]   nhi_ff  [AXES];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         for (int a = 0; a < AXES; a++) begin
            logic signed [PT_W-1:0] lo;
            logic signed [PT_W-1:0] hi;
            lo = (p1_ff[a] < p2_ff[a]) ? p1_ff[a] : p2_ff[a];
            hi = (p1_ff[a] < p2_ff[a]) ? p2_ff[a] : p1_ff[a];
            d1_ff[a]  <= d0_ff[a];
            nlo_ff[a] <= NUM_W'(lo) - NUM_W'(o0_ff[a]);
            nhi_ff[a] <= NUM_W'(hi) - NUM_W'(o0_ff[a]);
         end
      end
   end

   // divider pipe: entry 0 is the setup stage, entry k after k steps
   div_lane_type div_ff  [DIV_STEPS+1][LANES];
   side_type     side_ff [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (rdy[DIV0]) begin
         logic mz;
         mz = 1'b0;
         for (int a = 0; a < AXES; a++) begin
            logic                     zd;
            logic [COORD_W-1:0]       dabs;
            logic signed [NUM_W-1:0]  nm;
            logic signed [NUM_W-1:0]  ab;
            zd   = (d1_ff[a] == '0);
            dabs = d1_ff[a][COORD_W-1] ? COORD_W'(-d1_ff[a]) : COORD_W'(d1_ff[a]);
            side_ff[0].unb[a] <= zd;
            for (int s = 0; s < 2; s++) begin
               nm = (s == 0) ? nlo_ff[a] : nhi_ff[a];
               ab = nm[NUM_W-1] ? -nm : nm;
               div_ff[0][2*a+s].dd  <= dabs;
               div_ff[0][2*a+s].sh  <= {ab[MAG_W-1:0], {FRAC_W{1'b0}}};
               div_ff[0][2*a+s].rem <= '0;
               div_ff[0][2*a+s].neg <= nm[NUM_W-1] ^ d1_ff[a][COORD_W-1];
            end
            if (zd && !(nlo_ff[a] <= 0 && nhi_ff[a] >= 0)) begin
               mz = 1'b1;
            end
         end
         side_ff[0].miss <= mz;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (rdy[DIV0+k]) begin
            side_ff[k] <= side_ff[k-1];
            for (int l = 0; l < LANES; l++) begin
               logic [COORD_W:0] t;
               logic             ge;
               t  = {div_ff[k-1][l].rem, div_ff[k-1][l].sh[DIV_STEPS-1]};
               ge = (t >= {1'b0, div_ff[k-1][l].dd});
               div_ff[k][l].dd  <= div_ff[k-1][l].dd;
               div_ff[k][l].neg <= div_ff[k-1][l].neg;
               div_ff[k][l].sh  <= {div_ff[k-1][l].sh[DIV_STEPS-2:0], ge};
               div_ff[k][l].rem <= ge ? COORD_W'(t - {1'b0, div_ff[k-1][l].dd})
                                      : t[COORD_W-1:0];
            end
         end
      end
   end

   // floor quotient
   logic signed [T_W-1:0] q_ff [LANES];
   side_type              fix_side_ff;

   always_ff @(posedge clock) begin
      if (rdy[FIX]) begin
         fix_side_ff <= side_ff[DIV_STEPS];
         for (int l = 0; l < LANES; l++) begin
            logic [T_W-1:0] qm;
            qm = T_W'(div_ff[DIV_STEPS][l].sh);
            if (!div_ff[DIV_STEPS][l].neg) begin
               q_ff[l] <= qm;
            end else if (div_ff[DIV_STEPS][l].rem != '0) begin
               q_ff[l] <= ~qm;
            end else begin
               q_ff[l] <= -qm;
            end
         end
      end
   end

   // per-axis entry and exit
   logic signed [T_W-1:0] tin_ff  [AXES];
   logic signed [T_W-1:0] tout_ff [AXES];
   logic                  miss_axs_ff;

   always_ff @(posedge clock) begin
      if (rdy[AXS]) begin
         miss_axs_ff <= fix_side_ff.miss;
         for (int a = 0; a < AXES; a++) begin
            if (fix_side_ff.unb[a]) begin
               tin_ff[a]  <= T_NEG_INF;
               tout_ff[a] <= T_POS_INF;
            end else if (q_ff[2*a] < q_ff[2*a+1]) begin
               tin_ff[a]  <= q_ff[2*a];
               tout_ff[a] <= q_ff[2*a+1];
            end else begin
               tin_ff[a]  <= q_ff[2*a+1];
               tout_ff[a] <= q_ff[2*a];
            end
         end
      end
   end

   logic signed [T_W-1:0] tmin1_ff;
   logic signed [T_W-1:0] tmax1_ff;
   logic signed [T_W-1:0] tin2_ff;
   logic signed [T_W-1:0] tout2_ff;
   logic                  miss1_ff;

   always_ff @(posedge clock) begin
      if (rdy[CMB1]) begin
         miss1_ff <= miss_axs_ff;
         tmin1_ff <= (tin_ff[0] > tin_ff[1]) ? tin_ff[0] : tin_ff[1];
         tmax1_ff <= (tout_ff[0] < tout_ff[1]) ? tout_ff[0] : tout_ff[1];
         tin2_ff  <= tin_ff[2];
         tout2_ff <= tout_ff[2];
      end
   end

   logic signed [T_W-1:0] tmin_ff;
   logic signed [T_W-1:0] tmax_ff;
   logic                  miss2_ff;

   always_ff @(posedge clock) begin
      if (rdy[CMB2]) begin
         miss2_ff <= miss1_ff;
         tmin_ff  <= (tmin1_ff > tin2_ff) ? tmin1_ff : tin2_ff;
         tmax_ff  <= (tmax1_ff < tout2_ff) ? tmax1_ff : tout2_ff;
      end
   end

   logic              hit_ff;
   logic [DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (rdy[OUTS]) begin
         logic signed [T_W-1:0] t;
         logic                  h;
         t = (tmin_ff < 0) ? tmax_ff : tmin_ff;
         h = !miss2_ff && !(tmax_ff < 0) && !(tmin_ff > tmax_ff);
         hit_ff <= h;
         if (!h) begin
            dist_ff <= '0;
         end else if (t > DIST_MAX) begin
            dist_ff <= DIST_MAX[DIST_W-1:0];
         end else begin
            dist_ff <= t[DIST_W-1:0];
         end
      end
   end

   assign rsp_tvalid = v_ff[OUTS];
   assign rsp_tdata  = {dist_ff, hit_ff};
endmodule

[design/rbsi_checker.sv]
`timescale 1ns / 1ps
module rbsi_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [rbsi_pkg::OUT_W-1:0] rsp_tdata
);
   import rbsi_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[OUT_W-1:1] == '0))
      else $error("miss beat with nonzero distance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled rsp beat changed");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid) |-> req_tready)
      else $error("req stalled with output empty");
endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (.*);

[tb/ray_box_slab_intersect_tb.sv]
`timescale 1ns / 1ps
module ray_box_slab_intersect_tb;
   import rbsi_pkg::*;

   localparam longint T_INF_POS = 64'sh4000_0000_0000_0000;
   localparam longint T_INF_NEG = -64'sh4000_0000_0000_0000;
   localparam longint DMAX      = 64'sh7FFF_FFFF;
   localparam int     WD_LIMIT  = 20000;
   localparam int     N_RANDOM  = 1800;
   localparam int     DRAIN     = 120;
   localparam int     N_DIR     = 12;

   typedef struct {
      logic [COORD_W-1:0] f [12];
   } ray_box_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              hit;
   } hit_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [IN_W-1:0]   req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [OUT_W-1:0]  rsp_tdata;

   hit_type hit_q [$];
   int    errors;
   int    mism;
   int    idle_pct;
   int    stall_pct;
   bit    hold_off;
   bit    done;
   int    quiet;

   ray_box_slab_intersect dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic longint floor_div(longint num, longint den);
      longint n, q, r;
      n = num * 65536;
      q = n / den;
      r = n % den;
      if (r != 0 && ((r < 0) != (den < 0))) q -= 1;
      return q;
   endfunction

   function automatic hit_type slab_hit(ray_box_type it);
      longint tmin, tmax, o, d, c, h, p1, p2, lo, hi, ta, tb, t;
      bit ok;
      hit_type r;
      tmin = T_INF_NEG;
      tmax = T_INF_POS;
      ok = 1;
      for (int a = 0; a < 3; a++) begin
         o = longint'($signed(it.f[a]));
         d = longint'($signed(it.f[3+a]));
         c = longint'($signed(it.f[6+a]));
         h = longint'($signed(it.f[9+a]));
         p1 = c + h;
         p2 = c - h;
         lo = p1 < p2 ? p1 : p2;
         hi = p1 < p2 ? p2 : p1;
         if (d == 0) begin
            if (o < lo || o > hi) ok = 0;
         end else begin
            ta = floor_div(lo - o, d);
            tb = floor_div(hi - o, d);
            if ((ta < tb ? ta : tb) > tmin) tmin = ta < tb ? ta : tb;
            if ((ta < tb ? tb : ta) < tmax) tmax = ta < tb ? tb : ta;
         end
      end
      r = '0;
      if (ok && tmax >= 0 && tmin <= tmax) begin
         t = tmin < 0 ? tmax : tmin;
         if (t > DMAX) t = DMAX;
         r.hit = 1;
         r.distance = t[DIST_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [IN_W-1:0] pack_item(ray_box_type it);
      logic [IN_W-1:0] v;
      for (int i = 0; i < 12; i++) v[i*COORD_W +: COORD_W] = it.f[i];
      return v;
   endfunction

   function automatic logic [31:0] rand_coord();
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3, 4: return $urandom();
         default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      endcase
   endfunction

   function automatic ray_box_type rand_item();
      ray_box_type it;
      for (int i = 0; i < 12; i++) it.f[i] = rand_coord();
      if ($urandom_range(0, 3) != 0) begin
         // aim the ray at the box center
         for (int a = 0; a < 3; a++)
            it.f[3+a] = 32'($signed(it.f[6+a]) - $signed(it.f[a]));
         if ($urandom_range(0, 4) == 0) it.f[3 + $urandom_range(0, 2)] = 0;
      end
      return it;
   endfunction

   // leaves req_tvalid high; the caller drops it before pausing
   task automatic send(ray_box_type it, bit use_exp = 0, hit_type exp_r = '0);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= pack_item(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit_q.push_back(use_exp ? exp_r : slab_hit(it));
      @(negedge clock);
   endtask

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_off && !(stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      hit_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = hit_type'(rsp_tdata);
         if (hit_q.size() == 0) begin
            errors++;
            if (mism < 10) $display("unexpected beat %h", rsp_tdata);
            mism++;
         end else begin
            exp_r = hit_q.pop_front();
            if (got.hit !== exp_r.hit || got.distance !== exp_r.distance) begin
               errors++;
               if (mism < 10)
                  $display("mismatch: exp hit=%0d dist=%h got hit=%0d dist=%h",
                           exp_r.hit, exp_r.distance, got.hit, got.distance);
               mism++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || done)
         quiet <= 0;
      else begin
         quiet <= quiet + 1;
         if (quiet >= WD_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic wait_empty();
      while (hit_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      ray_box_type dir_tab [N_DIR];
      bit          dir_chk [N_DIR];
      hit_type     dir_exp [N_DIR];
      ray_box_type it;
      errors = 0; mism = 0; idle_pct = 0; stall_pct = 0; hold_off = 0; done = 0;
      reset = 1; req_tvalid = 0; req_tdata = '0; rsp_tready = 0;
      // unit box at origin, ray from -5 on x along +x: entry 4.0
      for (int r = 0; r < N_DIR; r++) begin
         for (int i = 0; i < 12; i++) dir_tab[r].f[i] = 0;
         for (int i = 9; i < 12; i++) dir_tab[r].f[i] = 32'h0001_0000;
         dir_tab[r].f[0] = 32'hFFFB_0000;
         dir_tab[r].f[3] = 32'h0001_0000;
         dir_chk[r] = 0;
         dir_exp[r] = '0;
      end
      dir_chk[0] = 1; dir_exp[0] = '{distance: 31'h0004_0000, hit: 1'b1};
      dir_tab[1].f[3] = 32'hFFFF_0000;            // pointing away: miss
      dir_chk[1] = 1; dir_exp[1] = '{distance: 31'h0, hit: 1'b0};
      dir_tab[2].f[0] = 0;                        // inside box: exit distance
      dir_chk[2] = 1; dir_exp[2] = '{distance: 31'h0001_0000, hit: 1'b1};
      dir_tab[3].f[0] = 0; dir_tab[3].f[3] = 0;   // all axes unbounded: saturate
      dir_chk[3] = 1; dir_exp[3] = '{distance: 31'h7FFF_FFFF, hit: 1'b1};
      dir_tab[4].f[1] = 32'h0002_0000;            // zero dir y, outside: miss
      dir_chk[4] = 1; dir_exp[4] = '{distance: 31'h0, hit: 1'b0};
      dir_tab[5].f[3] = 32'h0000_0001;            // tiny dir: saturate
      dir_chk[5] = 1; dir_exp[5] = '{distance: 31'h7FFF_FFFF, hit: 1'b1};
      dir_tab[6].f[9] = 32'hFFFF_0000;            // negative half extent
      for (int i = 0; i < 12; i++) dir_tab[7].f[i] = 32'h8000_0000;
      for (int i = 0; i < 12; i++) dir_tab[8].f[i] = 32'h7FFF_FFFF;
      for (int i = 0; i < 12; i++) dir_tab[9].f[i] = 32'hFFFF_FFFF;
      dir_tab[10].f[0] = 32'hFFFF_0000;           // entry exactly at face
      dir_tab[10].f[3] = 32'h0003_0000;
      dir_tab[11].f[3] = 32'h8000_0000;
      dir_tab[11].f[0] = 32'h7FFF_FFFF;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      stall_pct = 0;
      for (int r = 0; r < N_DIR; r++) send(dir_tab[r], dir_chk[r], dir_exp[r]);
      // long receiver hold-off while sender keeps offering
      hold_off = 1;
      fork
         begin
            repeat (200) @(negedge clock);
            hold_off = 0;
         end
         begin
            for (int k = 0; k < 100; k++) send(rand_item());
            req_tvalid <= 0;
         end
      join
      wait_empty();
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 22 : 0;
         stall_pct = (ph == 2) ? 50 : (ph == 3) ? 22 : 0;
         for (int k = 0; k < N_RANDOM / 4; k++) begin
            it = rand_item();
            if (k % 97 == 0) begin
               for (int i = 0; i < 12; i++) it.f[i] = ~it.f[i];
            end
            send(it);
         end
         req_tvalid <= 0;
         wait_empty();
      end
      stall_pct = 0;
      repeat (DRAIN) @(negedge clock);
      done = 1;
      if (errors == 0 && hit_q.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
